FILE: rtl/rau_pkg.sv
package rau_pkg;

  typedef enum logic [2:0] {
    OP_NORM = 3'd0,
    OP_ADD  = 3'd1,
    OP_SUB  = 3'd2,
    OP_MUL  = 3'd3,
    OP_DIV  = 3'd4,
    OP_EQ   = 3'd5
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ZERODEN = 2'd1,
    ST_DIVZERO = 2'd2,
    ST_OVF     = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_MUL3,
    S_SUM,
    S_GCD,
    S_DIVN,
    S_DIVD,
    S_CHECK,
    S_OUT
  } state_t;

endpackage

FILE: rtl/rational_arithmetic_unit.sv
// Rational arithmetic unit: takes two fractions a and b and an opcode (normalize a, add,
// subtract, multiply, divide, equality test) and returns one reduced fraction with a
// positive denominator and a status code (the equality test returns an equal flag in
// place of the fraction). Intermediates are exact 64-bit magnitudes; a reduced result that
// does not fit the output width is flagged as overflow. One item is in flight at a time.
// Up to three 32x32 products come from one shared multiplier, then a binary gcd and two
// 64-step restoring divisions by the gcd on a single shared 64-bit shift-subtract unit;
// error cases, a zero numerator and the equality test skip the gcd and the divisions.
module rational_arithmetic_unit import rau_pkg::*; #(
  parameter int WORD_BITS = 32
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [2:0]             req_type,
  input  logic signed [31:0]     a_num,
  input  logic signed [31:0]     a_den,
  input  logic signed [31:0]     b_num,
  input  logic signed [31:0]     b_den,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic signed [31:0]     res_num,
  output logic [30:0]            res_den,
  output logic                   is_equal,
  output logic [1:0]             status
);

  localparam logic [63:0] LIM = 64'd1 << (WORD_BITS - 1);

  state_t state, state_next;

  // operand magnitudes and signs
  logic [31:0] anm, adm, bnm, bdm;
  logic        ans, ads, bns, bds;
  logic [2:0]  op;
  // products and working values
  logic [63:0] p1, p2, nm, dm;
  logic        p1s, p2s, nneg;
  logic [63:0] gx, gy;
  logic [6:0]  gshift;
  logic [63:0] quo, rem, dvd;
  logic [6:0]  cnt;
  logic [63:0] qn;

  // shared multiplier operands
  logic [31:0] mx, my;
  logic [63:0] mprod;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  // multiplier operand select
  always_comb begin
    mx = anm;
    my = bdm;
    case (state)
      S_MUL1: begin mx = anm; my = (op == OP_MUL) ? bnm : bdm; end
      S_MUL2: begin mx = adm; my = (op == OP_MUL || op == OP_NORM) ? bdm : bnm; end
      S_MUL3: begin mx = adm; my = bdm; end
      default: ;
    endcase
  end
  assign mprod = {32'd0, mx} * {32'd0, my};

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_valid) state_next = S_MUL1;
      S_MUL1: begin
        if (op > OP_EQ) state_next = S_OUT;
        else if (adm == 32'd0 || (op != OP_NORM && bdm == 32'd0)) state_next = S_OUT;
        else if (op == OP_DIV && bnm == 32'd0) state_next = S_OUT;
        else if (op == OP_NORM) state_next = S_SUM;
        else state_next = S_MUL2;
      end
      S_MUL2: state_next = (op == OP_ADD || op == OP_SUB) ? S_MUL3 :
                           (op == OP_EQ) ? S_OUT : S_SUM;
      S_MUL3: state_next = S_SUM;
      S_SUM:  state_next = (p1 == 64'd0) ? S_CHECK : S_GCD;
      S_GCD:  if (gy == 64'd0) state_next = S_DIVN;
      S_DIVN: if (cnt == 7'd64) state_next = S_DIVD;
      S_DIVD: if (cnt == 7'd64) state_next = S_CHECK;
      S_CHECK: state_next = S_OUT;
      S_OUT:  if (out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  // datapath
  always_ff @(posedge clk) begin
    logic [64:0] trial;
    logic [63:0] rsh;
    unique case (state)
      S_IDLE: if (in_valid) begin
        op  <= req_type;
        anm <= mag32(a_num); ans <= a_num[31];
        adm <= mag32(a_den); ads <= a_den[31];
        bnm <= mag32(b_num); bds <= b_den[31];
        bdm <= mag32(b_den);
        // subtraction flips b's sign
        bns <= b_num[31] ^ (req_type == OP_SUB);
        res_num <= '0; res_den <= '0; is_equal <= 1'b0; status <= ST_OK;
      end
      S_MUL1: begin
        if (op > OP_EQ) status <= ST_OK;
        else if (adm == 32'd0 || (op != OP_NORM && bdm == 32'd0)) status <= ST_ZERODEN;
        else if (op == OP_DIV && bnm == 32'd0) status <= ST_DIVZERO;
        if (op == OP_NORM) begin
          p1 <= {32'd0, anm}; p1s <= ans;
          p2 <= {32'd0, adm}; p2s <= ads;
        end else begin
          p1 <= mprod;
          p1s <= ans ^ ((op == OP_MUL) ? bns : bds);
        end
      end
      S_MUL2: begin
        p2 <= mprod;
        p2s <= ads ^ ((op == OP_MUL) ? bds : bns);
        if (op == OP_EQ)
          is_equal <= (p1 == mprod) &&
                      (p1 == 64'd0 || p1s == (ads ^ bns));
      end
      S_MUL3: begin
        // numerator = p1 + p2 signed, denominator = mprod
        if (p1s == p2s) begin p1 <= p1 + p2; end
        else if (p1 >= p2) begin p1 <= p1 - p2; end
        else begin p1 <= p2 - p1; p1s <= p2s; end
        p2 <= mprod; p2s <= ads ^ bds;
      end
      S_SUM: begin
        nm <= p1; dm <= p2;
        nneg <= (p1 != 64'd0) && (p1s != p2s);
        gx <= p1; gy <= p2; gshift <= '0;
      end
      S_GCD: begin
        // binary gcd, one step a cycle
        if (gy == 64'd0) begin
          gx <= gx << gshift;
          cnt <= '0; quo <= '0; rem <= '0; dvd <= nm;
        end else if (!gx[0] && !gy[0]) begin
          gx <= gx >> 1; gy <= gy >> 1; gshift <= gshift + 7'd1;
        end else if (!gx[0]) gx <= gx >> 1;
        else if (!gy[0]) gy <= gy >> 1;
        else if (gx >= gy) begin gx <= gy; gy <= (gx - gy) >> 1; end
        else gy <= (gy - gx) >> 1;
      end
      S_DIVN, S_DIVD: begin
        if (cnt == 7'd64) begin
          cnt <= '0; rem <= '0; quo <= '0; dvd <= dm; qn <= quo;
          if (state == S_DIVD) begin nm <= qn; dm <= quo; end
        end else begin
          rsh = {rem[62:0], dvd[63]};
          trial = {1'b0, rsh} - {1'b0, gx};
          if (!trial[64] || rem[63]) begin
            rem <= trial[63:0]; quo <= {quo[62:0], 1'b1};
          end else begin
            rem <= rsh; quo <= {quo[62:0], 1'b0};
          end
          dvd <= {dvd[62:0], 1'b0};
          cnt <= cnt + 7'd1;
        end
      end
      S_CHECK: begin
        if (nm == 64'd0) begin
          res_num <= '0; res_den <= 31'd1;
        end else if (dm > LIM - 64'd1 || nm > (nneg ? LIM : LIM - 64'd1)) begin
          status <= ST_OVF;
        end else begin
          res_num <= nneg ? (~nm[31:0] + 32'd1) : nm[31:0];
          res_den <= dm[30:0];
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: verif/tb.sv
module tb;
  import rau_pkg::*;

  // one fraction pair request
  typedef struct packed {
    logic [2:0]         op;
    logic signed [31:0] an;
    logic signed [31:0] ad;
    logic signed [31:0] bn;
    logic signed [31:0] bd;
  } frac_req_t;

  // one reduced result
  typedef struct packed {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               eq;
    logic [1:0]         st;
  } frac_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] req_type = '0;
  logic signed [31:0] a_num = '0, a_den = '0, b_num = '0, b_den = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] res_num;
  logic [30:0] res_den;
  logic is_equal;
  logic [1:0] status;

  frac_req_t pending_reqs[$];
  frac_res_t expected_res[$];
  int errors = 0;
  bit stim_done = 0;
  bit drain_pause = 0;
  bit in_taken = 0;
  bit long_hold_done = 0;
  int hold_cycles = 0;
  int send_gap = 0;
  int recv_gap = 0;

  rational_arithmetic_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .req_type(req_type), .a_num(a_num), .a_den(a_den), .b_num(b_num), .b_den(b_den),
    .out_valid(out_valid), .out_ready(out_ready),
    .res_num(res_num), .res_den(res_den), .is_equal(is_equal), .status(status)
  );

  always #2 clk = ~clk;

  // signed 32-bit to sign and 64-bit magnitude
  function automatic void split_sm(input logic [31:0] v, output bit neg,
                                   output logic [63:0] mag);
    neg = v[31];
    mag = neg ? {32'd0, (~v + 32'd1)} : {32'd0, v};
  endfunction

  function automatic logic [63:0] euclid_gcd(input logic [63:0] x, input logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  // exact fraction arithmetic on sign/magnitude intermediates
  function automatic frac_res_t predict_fraction(input frac_req_t r);
    frac_res_t o;
    bit san, sad, sbn, sbd, nneg, dneg, lneg, rneg, neg;
    logic [63:0] man, mad, mbn, mbd, nm, dm, lm, rm, g;
    o = '0;
    split_sm(r.an, san, man);
    split_sm(r.ad, sad, mad);
    split_sm(r.bn, sbn, mbn);
    split_sm(r.bd, sbd, mbd);
    if (r.op > OP_EQ) return o;
    if (mad == 0 || (r.op != OP_NORM && mbd == 0)) begin
      o.st = ST_ZERODEN;
      return o;
    end
    if (r.op == OP_DIV && mbn == 0) begin
      o.st = ST_DIVZERO;
      return o;
    end
    if (r.op == OP_SUB && mbn != 0) sbn = ~sbn;
    // cross products
    lm = man * mbd; lneg = (san != sbd) && lm != 0;
    rm = mad * mbn; rneg = (sad != sbn) && rm != 0;
    case (r.op)
      OP_NORM: begin
        nm = man; nneg = san; dm = mad; dneg = sad;
      end
      OP_ADD, OP_SUB: begin
        if (lneg == rneg) begin
          nneg = lneg; nm = lm + rm;
        end else if (lm >= rm) begin
          nneg = lneg; nm = lm - rm;
        end else begin
          nneg = rneg; nm = rm - lm;
        end
        dm = mad * mbd; dneg = sad != sbd;
      end
      OP_MUL: begin
        nm = man * mbn; nneg = san != sbn;
        dm = mad * mbd; dneg = sad != sbd;
      end
      OP_DIV: begin
        nm = lm; nneg = lneg; dm = rm; dneg = rneg;
      end
      default: begin
        o.eq = (lneg == rneg) && (lm == rm);
        return o;
      end
    endcase
    neg = nneg != dneg;
    if (nm == 0) begin
      dm = 1;
      neg = 0;
    end else begin
      g = euclid_gcd(nm, dm);
      nm = nm / g;
      dm = dm / g;
    end
    if (dm > 64'h7FFF_FFFF || nm > (neg ? 64'h8000_0000 : 64'h7FFF_FFFF)) begin
      o.st = ST_OVF;
      return o;
    end
    o.num = neg ? (~nm[31:0] + 32'd1) : nm[31:0];
    o.den = dm[30:0];
    o.st = ST_OK;
    return o;
  endfunction

  function automatic logic [31:0] pick_word(input int mode);
    logic [31:0] w;
    case (mode)
      0: w = $urandom_range(0, 20) - 10;
      1: w = $urandom;
      2: w = 32'h8000_0000 + $urandom_range(0, 3);
      3: w = 32'h7FFF_FFFF - $urandom_range(0, 3);
      4: w = ($urandom_range(1, 3000)) * ($urandom_range(0, 1) ? -1 : 1);
      default: w = 32'd1 << $urandom_range(0, 31);
    endcase
    return w;
  endfunction

  function automatic frac_req_t mk_req(input logic [2:0] op, input logic [31:0] an,
                                       input logic [31:0] ad, input logic [31:0] bn,
                                       input logic [31:0] bd);
    frac_req_t r;
    r.op = op; r.an = an; r.ad = ad; r.bn = bn; r.bd = bd;
    return r;
  endfunction

  function automatic int rand_gap();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 300);
  endfunction

  // stimulus fill
  initial begin
    frac_req_t r;
    int dsel;
    pending_reqs.push_back(mk_req(OP_NORM, 32'sd6, -32'sd4, 0, 0));
    pending_reqs.push_back(mk_req(OP_NORM, 0, -32'sd7, 0, 0));
    pending_reqs.push_back(mk_req(OP_NORM, 32'sd5, 0, 0, 0));
    pending_reqs.push_back(mk_req(OP_NORM, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0));
    pending_reqs.push_back(mk_req(OP_NORM, 32'h8000_0000, 32'h0000_0001, 0, 0));
    pending_reqs.push_back(mk_req(OP_NORM, 32'h7FFF_FFFF, 32'h8000_0000, 0, 0));
    pending_reqs.push_back(mk_req(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 32'sd3));
    pending_reqs.push_back(mk_req(OP_ADD, 32'h7FFF_FFFF, 32'sd1, 32'h7FFF_FFFF, 32'sd1));
    pending_reqs.push_back(mk_req(OP_ADD, 32'sd1, 32'sd2, 32'sd1, 0));
    pending_reqs.push_back(mk_req(OP_SUB, 32'sd1, 32'sd2, 32'sd1, 32'sd2));
    pending_reqs.push_back(mk_req(OP_SUB, 32'h8000_0000, 32'sd1, 32'sd1, 32'sd1));
    pending_reqs.push_back(mk_req(OP_SUB, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h7FFF_FFFF));
    pending_reqs.push_back(mk_req(OP_MUL, 32'h8000_0000, 32'sd3, 32'h8000_0000, 32'sd5));
    pending_reqs.push_back(mk_req(OP_MUL, -32'sd2, 32'sd3, 32'sd3, -32'sd4));
    pending_reqs.push_back(mk_req(OP_DIV, 32'sd1, 32'sd2, 0, 32'sd3));
    pending_reqs.push_back(mk_req(OP_DIV, 32'sd3, 32'sd4, -32'sd9, 32'sd8));
    pending_reqs.push_back(mk_req(OP_DIV, 32'sd1, 32'h7FFF_FFFF, 32'sd1, 32'h8000_0000));
    pending_reqs.push_back(mk_req(OP_EQ, 32'sd1, 32'sd2, -32'sd2, -32'sd4));
    pending_reqs.push_back(mk_req(OP_EQ, 32'sd1, 32'sd2, 32'sd2, 32'sd3));
    pending_reqs.push_back(mk_req(OP_EQ, 0, 32'sd5, 0, -32'sd3));
    pending_reqs.push_back(mk_req(OP_EQ, 32'sd1, 32'sd2, 32'sd1, 0));
    pending_reqs.push_back(mk_req(3'd6, 32'sd1, 32'sd2, 32'sd3, 32'sd4));
    pending_reqs.push_back(mk_req(3'd7, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 0));
    for (int i = 0; i < 1600; i++) begin
      dsel = $urandom_range(0, 5);
      r.op = ($urandom_range(0, 49) == 0) ? 3'($urandom_range(6, 7))
                                           : 3'($urandom_range(0, 5));
      r.an = pick_word($urandom_range(0, 5));
      r.ad = pick_word(dsel);
      r.bn = pick_word($urandom_range(0, 5));
      r.bd = pick_word($urandom_range(0, 5));
      // keep zero denominators occasional
      if (r.ad == 0 && $urandom_range(0, 3) != 0) r.ad = 32'sd1;
      if (r.bd == 0 && $urandom_range(0, 3) != 0) r.bd = -32'sd1;
      // an equal pair now and then
      if (r.op == OP_EQ && $urandom_range(0, 1)) begin
        r.bn = r.an * 3; r.bd = r.ad * 3;
      end
      pending_reqs.push_back(r);
    end
  end

  // reset
  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
  end

  // driver
  int sent = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
        // holding until accepted
      end else if (drain_pause) begin
        in_valid <= 1'b0;
        if (expected_res.size() == 0) drain_pause <= 1'b0;
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pending_reqs.size() != 0) begin
        frac_req_t r;
        r = pending_reqs.pop_front();
        in_valid <= 1'b1;
        req_type <= r.op; a_num <= r.an; a_den <= r.ad; b_num <= r.bn; b_den <= r.bd;
        sent <= sent + 1;
        if (sent == 300) drain_pause <= 1'b1;
        send_gap <= rand_gap();
      end else begin
        in_valid <= 1'b0;
        stim_done <= 1'b1;
      end
    end
  end

  // expectation on input accept
  always @(posedge clk) begin
    in_taken <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready)
      expected_res.push_back(predict_fraction({req_type, a_num, a_den, b_num, b_den}));
  end

  // receiver backpressure, one long hold counted here
  int recv_count = 0;
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else if (recv_count == 100 && !long_hold_done) begin
      out_ready <= 1'b0;
      hold_cycles <= 2000;
      long_hold_done <= 1'b1;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      out_ready <= 1'b1;
      recv_gap <= rand_gap();
    end
  end

  // monitor
  always @(posedge clk) begin
    frac_res_t e;
    if (!rst && out_valid && out_ready) begin
      recv_count <= recv_count + 1;
      if (expected_res.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d eq=%0b st=%0d", $time,
                 res_num, res_den, is_equal, status);
        errors++;
      end else begin
        e = expected_res.pop_front();
        if (res_num !== e.num || res_den !== e.den || is_equal !== e.eq ||
            status !== e.st) begin
          $display("%0t: mismatch expected num=%0d den=%0d eq=%0b st=%0d", $time,
                   e.num, e.den, e.eq, e.st);
          $display("%0t:          actual   num=%0d den=%0d eq=%0b st=%0d", $time,
                   res_num, res_den, is_equal, status);
          errors++;
        end
      end
    end
  end

  // end of run
  initial begin
    wait (stim_done);
    wait (expected_res.size() == 0);
    repeat (400) @(posedge clk);
    if (errors == 0)
      $display("tb: clean");
    else
      $display("tb: errors");
    $finish;
  end

  initial begin
    #40000000;
    $display("tb: errors");
    $finish;
  end

endmodule

FILE: rational_arithmetic_unit.f
rtl/rau_pkg.sv
rtl/rational_arithmetic_unit.sv
verif/tb.sv
